/* src/modexp_pkg.sv */
// modexp_pkg: widths, reduction constants and sequencer codes for the
// modular exponentiation block. No dependencies.
`timescale 1ns / 1ps

package modexp_pkg;

  // field widths of the transfer payloads
  localparam int BASE_W  = 63;
  localparam int EXP_W   = 63;
  localparam int POWER_W = 30;

  // fixed prime modulus
  localparam longint unsigned MODULUS = 64'd1000000007;

  // bits in the modulus and derived datapath widths
  localparam int MOD_W = $clog2(MODULUS + 64'd1);
  localparam int PROD_W = 2 * MOD_W;          // a full residue product
  localparam int MUL_W = MOD_W + 2;           // shared multiplier operand width
  localparam int MUL_PW = 2 * MUL_W;          // shared multiplier result width

  // barrett reciprocal, floor(2^(2k) / m)
  localparam longint unsigned MU = (64'd1 << (2 * MOD_W)) / MODULUS;
  localparam logic [MUL_W-1:0] MU_C = MUL_W'(MU);
  localparam logic [MUL_W-1:0] MOD_C = MUL_W'(MODULUS);

  // base is folded in digits of MOD_W bits, most significant first
  localparam int NDIG = (BASE_W + MOD_W - 1) / MOD_W;
  localparam int BPAD_W = NDIG * MOD_W;
  localparam int DIG_W = $clog2(NDIG + 1);

  // sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_BDIG = 3'd1;
  localparam logic [ST_W-1:0] ST_NEXT = 3'd2;
  localparam logic [ST_W-1:0] ST_MULT = 3'd3;
  localparam logic [ST_W-1:0] ST_RED1 = 3'd4;
  localparam logic [ST_W-1:0] ST_RED2 = 3'd5;
  localparam logic [ST_W-1:0] ST_RED3 = 3'd6;
  localparam logic [ST_W-1:0] ST_DONE = 3'd7;

  // operation in flight on the shared multiplier
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_BASE = 2'd0;  // fold one base digit
  localparam logic [OP_W-1:0] OP_ACC  = 2'd1;  // result times current power
  localparam logic [OP_W-1:0] OP_SQR  = 2'd2;  // square the current power

endpackage

/* src/modular_exponentiation.sv */
// modular_exponentiation: top level, sequencer and residue registers.
// Depends on modexp_pkg, modexp_mul and modexp_fix.
`timescale 1ns / 1ps

// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply.
// Input channel: in_base, in_exponent with in_valid / in_stall. A transfer
// happens when in_valid is high and in_stall low. in_stall stays high from
// the transfer until the result has been taken, one item at a time; the next
// input transfer can come in the cycle after the result transfer.
// Result channel: out_power with out_valid / out_stall. out_valid holds
// with a stable out_power while out_stall is high; the block waits.
// Each modular multiply runs on the shared multiplier, followed by the
// barrett reduction (reciprocal multiply and quotient times modulus on that
// same multiplier, then subtract and correct) and a decision step. The base
// is folded in 3 digits. For an exponent of bit length L with c set bits,
// L - 1 + c modular multiplies follow; an exponent of zero gives 1.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// any item in progress; no other state is kept between items.
module modular_exponentiation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [modexp_pkg::BASE_W-1:0]   in_base,
  input  logic [modexp_pkg::EXP_W-1:0]    in_exponent,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [modexp_pkg::POWER_W-1:0]  out_power
);
  import modexp_pkg::*;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [BPAD_W-1:0] base_r, base_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [MOD_W-1:0]  acc_r, acc_nxt;
  logic [MOD_W-1:0]  sq_r, sq_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [MUL_PW-1:0] prod;
  logic [PROD_W-1:0] p_cur;
  logic [MOD_W:0]    q1;
  logic [MOD_W:0]    q3;
  logic [MOD_W-1:0]  r;
  logic              in_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DONE);
  assign out_power = POWER_W'(acc_r);

  // barrett quotient estimate pieces
  assign p_cur = (op_r == OP_BASE) ? p_r : prod[PROD_W-1:0];
  assign q1    = p_cur[PROD_W-1:MOD_W-1];
  assign q3    = prod[PROD_W+1:MOD_W+1];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MULT: begin
        mul_a = (op_r == OP_ACC) ? MUL_W'(acc_r) : MUL_W'(sq_r);
        mul_b = MUL_W'(sq_r);
      end
      ST_RED1: begin
        mul_a = MUL_W'(q1);
        mul_b = MU_C;
      end
      ST_RED2: begin
        mul_a = MUL_W'(q3);
        mul_b = MOD_C;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  modexp_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  modexp_fix u_fix (
    .p_i  (p_r),
    .qm_i (prod[PROD_W-1:0]),
    .r_o  (r)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    p_nxt     = p_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          base_nxt  = BPAD_W'(in_base);
          exp_nxt   = in_exponent;
          dig_nxt   = DIG_W'(NDIG);
          acc_nxt   = MOD_W'(1);
          sq_nxt    = '0;
          op_nxt    = OP_BASE;
          state_nxt = ST_BDIG;
        end
      end
      // fold the next base digit into the running residue
      ST_BDIG: begin
        p_nxt     = {sq_r, base_r[BPAD_W-1 -: MOD_W]};
        base_nxt  = base_r << MOD_W;
        dig_nxt   = dig_r - DIG_W'(1);
        state_nxt = ST_RED1;
      end
      // pick the next multiply from the exponent
      ST_NEXT: begin
        if (exp_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          op_nxt    = exp_r[0] ? OP_ACC : OP_SQR;
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        state_nxt = ST_RED1;
      end
      ST_RED1: begin
        p_nxt     = p_cur;
        state_nxt = ST_RED2;
      end
      ST_RED2: begin
        state_nxt = ST_RED3;
      end
      // write back the reduced residue
      ST_RED3: begin
        case (op_r)
          OP_BASE: begin
            sq_nxt    = r;
            state_nxt = (dig_r == '0) ? ST_NEXT : ST_BDIG;
          end
          OP_ACC: begin
            acc_nxt   = r;
            exp_nxt   = {exp_r[EXP_W-1:1], 1'b0};
            state_nxt = ST_NEXT;
          end
          OP_SQR: begin
            sq_nxt    = r;
            exp_nxt   = exp_r >> 1;
            state_nxt = ST_NEXT;
          end
          default: begin
            state_nxt = ST_NEXT;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    dig_r  <= dig_nxt;
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    p_r    <= p_nxt;
  end

endmodule

/* src/modexp_mul.sv */
// modexp_mul: the shared multiplier with a registered product.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_mul (
  input  logic                           clk,
  input  logic [modexp_pkg::MUL_W-1:0]   a_i,
  input  logic [modexp_pkg::MUL_W-1:0]   b_i,
  output logic [modexp_pkg::MUL_PW-1:0]  prod_o
);
  import modexp_pkg::*;

  logic [MUL_PW-1:0] prod_r;

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

  assign prod_o = prod_r;

endmodule

/* src/modexp_fix.sv */
// modexp_fix: last barrett step, remainder p - q*m and final correction
// into 0..m-1. Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_fix (
  input  logic [modexp_pkg::PROD_W-1:0] p_i,
  input  logic [modexp_pkg::PROD_W-1:0] qm_i,
  output logic [modexp_pkg::MOD_W-1:0]  r_o
);
  import modexp_pkg::*;

  localparam logic [MOD_W+1:0] M1 = (MOD_W + 2)'(MODULUS);
  localparam logic [MOD_W+1:0] M2 = (MOD_W + 2)'(2 * MODULUS);

  logic [PROD_W-1:0] diff;
  logic [MOD_W+1:0]  r3;
  logic [MOD_W+1:0]  rc;

  // remainder estimate lies below 3m, so its low bits are exact
  assign diff = p_i - qm_i;
  assign r3   = diff[MOD_W+1:0];

  // subtract m once or twice
  always_comb begin
    if (r3 >= M2) begin
      rc = r3 - M2;
    end else if (r3 >= M1) begin
      rc = r3 - M1;
    end else begin
      rc = r3;
    end
  end

  assign r_o = rc[MOD_W-1:0];

endmodule

/* verif/modular_exponentiation_tb.sv */
// modular_exponentiation_tb: self-checking testbench for modular_exponentiation.
// Depends on modexp_pkg and the modular_exponentiation RTL; predicts each power
// by square-and-multiply on 64-bit integers and checks every result transfer.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  typedef struct {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    bit                drain;    // wait for every pending power before sending
  } power_req_t;

  // receiver stall patterns
  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_HEAVY  = 2;

  localparam logic [62:0] ALL_ONES = {63{1'b1}};
  localparam int          LONG_HOLD_AT = 300;
  localparam int          LONG_HOLD_CYCLES = 3000;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BASE_W-1:0]   in_base = '0;
  logic [EXP_W-1:0]    in_exponent = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [POWER_W-1:0]  out_power;

  power_req_t          pending_reqs[$];
  logic [POWER_W-1:0]  expected_powers[$];
  int                  n_sent = 0;
  int                  n_checked = 0;
  int                  n_fail = 0;
  int                  burst_left = 0;
  int                  gap_left = 0;
  int                  rx_mode = RX_FREE;
  int                  rx_run_left = 0;
  int                  hold_left = 0;
  bit                  long_hold_done = 1'b0;

  modular_exponentiation uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_power   (out_power)
  );

  // right-to-left square-and-multiply, all products below 2^60
  function automatic logic [POWER_W-1:0] expected_power(input logic [BASE_W-1:0] b,
                                                        input logic [EXP_W-1:0] e);
    longint unsigned m;
    longint unsigned acc;
    longint unsigned sq;
    m = MODULUS;
    acc = 64'd1 % m;
    sq = {1'b0, b} % m;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[POWER_W-1:0];
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  task automatic queue_power(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                             input bit drain);
    power_req_t req;
    req.base = b;
    req.exponent = e;
    req.drain = drain;
    pending_reqs = {pending_reqs, req};
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #60_000_000;
    $display("modular_exponentiation_tb: FAIL");
    $finish;
  end

  // input driver: bursts of transfers with random gaps
  always @(posedge clk) begin : driver
    bit fire;
    bit offer;
    fire = in_valid && !in_stall;
    offer = 1'b0;
    if (rst_n && (!in_valid || fire)) begin
      if (fire) begin
        n_sent++;
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        offer = !pending_reqs[0].drain || (n_checked == n_sent);
      end
      if (offer) begin
        in_base <= pending_reqs[0].base;
        in_exponent <= pending_reqs[0].exponent;
        pending_reqs.pop_front();
      end
      in_valid <= offer;
    end
  end

  // receiver stall pattern, with one long hold-off after a few hundred results
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && n_checked >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_HEAVY);
        rx_run_left = $urandom_range(20, 200);
      end
      rx_run_left--;
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        default:   out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: check result transfers, then record the power for each input transfer
  always @(posedge clk) begin : monitor
    logic [POWER_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          $error("unexpected result transfer: out_power %0d", out_power);
          n_fail++;
        end else begin
          want = expected_powers.pop_front();
          if (out_power !== want) begin
            $error("out_power mismatch: expected %0d, actual %0d", want, out_power);
            n_fail++;
          end
        end
        n_checked <= n_checked + 1;
      end
      if (in_valid && !in_stall)
        expected_powers = {expected_powers, expected_power(in_base, in_exponent)};
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    logic [63:0]       mask;

    // zero exponent and zero base corners
    queue_power(63'd0, 63'd0, 1'b0);
    queue_power(63'd0, 63'd1, 1'b0);
    queue_power(63'd0, ALL_ONES, 1'b0);
    queue_power(ALL_ONES, 63'd0, 1'b0);
    queue_power(ALL_ONES, 63'd1, 1'b0);
    queue_power(ALL_ONES, ALL_ONES, 1'b0);
    queue_power(63'd1, ALL_ONES, 1'b0);
    // bases that are multiples of the prime
    queue_power(63'(MODULUS), 63'd0, 1'b0);
    queue_power(63'(MODULUS), 63'd1, 1'b0);
    queue_power(63'(MODULUS * 3), ALL_ONES, 1'b0);
    // residues next to the prime
    queue_power(63'(MODULUS - 1), 63'd2, 1'b0);
    queue_power(63'(MODULUS - 1), 63'd3, 1'b0);
    queue_power(63'(MODULUS + 1), ALL_ONES, 1'b0);
    queue_power(63'd3, 63'(MODULUS - 1), 1'b0);
    queue_power(63'd7, 63'(MODULUS - 2), 1'b0);
    queue_power(63'd2, 63'd30, 1'b0);
    queue_power(63'd2, 63'd31, 1'b0);
    // single high bits and alternating patterns
    queue_power(63'd1 << 62, 63'd1 << 62, 1'b0);
    queue_power(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    queue_power(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0);

    // random part: mostly short exponents, a quarter at full width
    for (int i = 0; i < 1630; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 63'(64'($urandom_range(0, 1000)) * MODULUS);
        1:       b = 63'($urandom_range(0, 15));
        2:       b = rand63() >> $urandom_range(0, 62);
        default: b = rand63();
      endcase
      if ($urandom_range(0, 3) == 0) begin
        e = rand63();
      end else begin
        mask = (64'd1 << $urandom_range(0, 24)) - 64'd1;
        e = rand63() & mask[62:0];
      end
      queue_power(b, e, (i % 400) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items sent, no power outstanding
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_powers.size() != 0);
    repeat (700) @(negedge clk);

    if (n_fail == 0) begin
      $display("modular_exponentiation_tb: PASS");
    end else begin
      $display("modular_exponentiation_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/modexp_pkg.sv
src/modexp_mul.sv
src/modexp_fix.sv
src/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
